>>> rtl/spg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sigmoid parameter gradient package
// Shared widths, register codes, reset values and the exp helper used to
// build the sigmoid table at elaboration.
// ----------------------------------------------------------------------------
package spg_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	// Field widths.
	localparam int X_W       = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int GG_W      = 16;
	localparam int GRAD_W    = 32;

	// Internal datapath widths.
	localparam int D_W    = 17;
	localparam int Z_W    = 33;
	localparam int FR_W   = 20;
	localparam int ENT_W  = 17;
	localparam int DIFF_W = 16;
	localparam int P_W    = 31;
	localparam int PROD_W = 64;
	localparam int RND_W  = 33;

	// Number of register stages between input and output.
	localparam int PIPE_STAGES = 11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 2'd2;

	localparam logic signed [CFG_W-1:0] GAIN_RST     = 16'sd256;
	localparam logic signed [CFG_W-1:0] SLOPE_RST    = 16'sd256;
	localparam logic signed [CFG_W-1:0] X_OFFSET_RST = 16'sd0;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	// exp(-16*u) for u in Q0.30 over [0,1], result in Q0.30. Taylor series
	// of exp(-u) in Horner form, then squared four times with rounding.
	function automatic logic [63:0] exp_neg16(input logic [63:0] u);
		logic [63:0] r;
		r = Q30_ONE;
		r = Q30_ONE - ((u * r) >> 30) / 64'd14;
		r = Q30_ONE - ((u * r) >> 30) / 64'd13;
		r = Q30_ONE - ((u * r) >> 30) / 64'd12;
		r = Q30_ONE - ((u * r) >> 30) / 64'd11;
		r = Q30_ONE - ((u * r) >> 30) / 64'd10;
		r = Q30_ONE - ((u * r) >> 30) / 64'd9;
		r = Q30_ONE - ((u * r) >> 30) / 64'd8;
		r = Q30_ONE - ((u * r) >> 30) / 64'd7;
		r = Q30_ONE - ((u * r) >> 30) / 64'd6;
		r = Q30_ONE - ((u * r) >> 30) / 64'd5;
		r = Q30_ONE - ((u * r) >> 30) / 64'd4;
		r = Q30_ONE - ((u * r) >> 30) / 64'd3;
		r = Q30_ONE - ((u * r) >> 30) / 64'd2;
		r = Q30_ONE - ((u * r) >> 30);
		for (int i = 0; i < 4; i++) begin
			r = (r * r + (64'd1 << 29)) >> 30;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/spg_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sigmoid parameter gradient channels
// Valid/ready channels for samples, gradient results and register writes.
// ----------------------------------------------------------------------------
interface spg_sample_if;
	logic                           valid;
	logic                           ready;
	logic signed [spg_pkg::X_W-1:0] sample_x;

	modport source (output valid, output sample_x, input ready);
	modport sink (input valid, input sample_x, output ready);
endinterface

interface spg_grad_if;
	logic                              valid;
	logic                              ready;
	logic        [spg_pkg::GG_W-1:0]   grad_gain;
	logic signed [spg_pkg::GRAD_W-1:0] grad_x;
	logic signed [spg_pkg::GRAD_W-1:0] grad_slope;
	logic signed [spg_pkg::GRAD_W-1:0] grad_x_offset;

	modport source (output valid, output grad_gain, output grad_x, output grad_slope,
		output grad_x_offset, input ready);
	modport sink (input valid, input grad_gain, input grad_x, input grad_slope,
		input grad_x_offset, output ready);
endinterface

interface spg_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [spg_pkg::CFG_IDX_W-1:0]    index;
	logic [spg_pkg::CFG_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/sigmoid_parameter_gradient_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sigmoid parameter gradient core
// Gradients of gain*sigmoid(slope*(x - x_offset)) with respect to gain, x,
// slope and x offset, one sample per clock unless stalled, in eleven stages.
// ----------------------------------------------------------------------------
// The core takes one signed Q8.8 sample per clock and returns one result
// transaction per sample, in order. Throughput is one transaction per clock
// while the output side is ready; the pipeline depth is set by the chain of
// dependent multiplies (slope*d, the table interpolation, s*(1-s) and the
// final gain product), each of which has a stage of its own. Every stage
// moves forward whenever the stage after it is empty or moving, so a stalled
// output only holds back the stages that are full, and empty stages keep
// filling. The sigmoid is read from a constant table of SIGMOID_TABLE_DEPTH+1
// points over [0,16] and linearly interpolated; there is no clearing pass
// after reset. Gain, slope and x offset are written through the configuration
// channel, which is always ready; they must only change while no sample is in
// flight.
// ----------------------------------------------------------------------------
module sigmoid_parameter_gradient_core #(
	parameter int SIGMOID_TABLE_DEPTH = spg_pkg::TABLE_DEPTH_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	spg_cfg_if.sink     cfg,
	spg_sample_if.sink  samp,
	spg_grad_if.source  grad
);

	localparam int NS    = spg_pkg::PIPE_STAGES;
	localparam int IDX_W = $clog2(SIGMOID_TABLE_DEPTH);
	localparam int POS_W = spg_pkg::FR_W + $clog2(SIGMOID_TABLE_DEPTH + 1);
	localparam int IP_W  = spg_pkg::DIFF_W + spg_pkg::FR_W + 1;
	localparam int S2_W  = 2 * spg_pkg::ENT_W;

	localparam logic [spg_pkg::ENT_W-1:0] S_ONE = spg_pkg::ENT_W'(65536);
	localparam logic [IP_W-1:0] IP_HALF = IP_W'(1) << (spg_pkg::FR_W - 1);

	localparam logic signed [spg_pkg::PROD_W:0] BIAS_POS = 65'sd2147483648;
	localparam logic signed [spg_pkg::PROD_W:0] BIAS_NEG = 65'sd2147483647;

	localparam logic signed [spg_pkg::GRAD_W-1:0] GRAD_MAX = 32'sh7FFFFFFF;
	localparam logic signed [spg_pkg::GRAD_W-1:0] GRAD_MIN = 32'sh80000000;

	// Saturate a rounded value to the 32-bit result range.
	function automatic logic signed [spg_pkg::GRAD_W-1:0] sat32(
		input logic signed [spg_pkg::RND_W-1:0] v
	);
		logic signed [spg_pkg::GRAD_W-1:0] r;
		if (v > spg_pkg::RND_W'(GRAD_MAX)) begin
			r = GRAD_MAX;
		end else if (v < spg_pkg::RND_W'(GRAD_MIN)) begin
			r = GRAD_MIN;
		end else begin
			r = v[spg_pkg::GRAD_W-1:0];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [spg_pkg::CFG_W-1:0]  gain_q;
	logic signed [spg_pkg::CFG_W-1:0]  slope_q;
	logic signed [spg_pkg::CFG_W-1:0]  xoff_q;
	logic signed [spg_pkg::GRAD_W-1:0] gsl_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= spg_pkg::GAIN_RST;
			slope_q <= spg_pkg::SLOPE_RST;
			xoff_q  <= spg_pkg::X_OFFSET_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				spg_pkg::CFG_GAIN:     gain_q  <= cfg.data;
				spg_pkg::CFG_SLOPE:    slope_q <= cfg.data;
				spg_pkg::CFG_X_OFFSET: xoff_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// The gain*slope product only changes with the registers, so it is kept
	// in a register of its own instead of riding down the pipeline. It
	// settles in the cycle after a write, long before a new sample reaches it.
	always_ff @(posedge clk) begin
		gsl_q <= spg_pkg::GRAD_W'(gain_q) * spg_pkg::GRAD_W'(slope_q);
	end

	// ------------------------------------------------------------------
	// Pipeline flow control
	// ------------------------------------------------------------------
	// adv[k] is high when stage k loads this clock: it is empty, or the
	// stage after it moves too. The last stage is the output register.
	logic [NS:1] vld_q;
	logic [NS:1] adv;

	assign adv[NS] = !vld_q[NS] || grad.ready;
	for (genvar k = 1; k < NS; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end

	assign samp.ready = adv[1];
	assign grad.valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[1] <= 1'b0;
		end else if (adv[1]) begin
			vld_q[1] <= samp.valid;
		end
	end

	for (genvar k = 2; k <= NS; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	logic signed [spg_pkg::D_W-1:0] d_s1, d_s2, d_s3, d_s4, d_s5, d_s6, d_s7;
	logic signed [spg_pkg::Z_W-1:0] z_s2;

	logic [spg_pkg::FR_W-1:0] a_s3;
	logic                     big_s3, big_s4, big_s5, big_s6;
	logic                     neg_s3, neg_s4, neg_s5, neg_s6;

	logic [IDX_W-1:0]          idx_s4;
	logic [spg_pkg::FR_W-1:0]  fr_s4, fr_s5;

	logic [spg_pkg::ENT_W-1:0]  lo_s5, lo_s6;
	logic [spg_pkg::DIFF_W-1:0] diff_s5;
	logic [spg_pkg::ENT_W-1:0]  last_ent;
	logic [spg_pkg::DIFF_W-1:0] interp_s6;

	logic [spg_pkg::ENT_W-1:0] s_s7;

	logic        [spg_pkg::P_W-1:0]  p_s8;
	logic signed [spg_pkg::Z_W-1:0]  gd_s8;
	logic        [spg_pkg::GG_W-1:0] gg_s8, gg_s9, gg_s10, gg_s11;

	logic signed [spg_pkg::PROD_W-1:0] vx_s9, vs_s9;
	logic signed [spg_pkg::RND_W-1:0]  rx_s10, rs_s10;

	logic signed [spg_pkg::GRAD_W-1:0] gx_s11, gs_s11, gxo_s11;

	// Combinational values between stages.
	logic        [spg_pkg::Z_W-1:0]    z_abs;
	logic        [POS_W-1:0]           pos;
	logic        [IP_W-1:0]            ip;
	logic        [spg_pkg::ENT_W-1:0]  sp;
	logic        [spg_pkg::ENT_W-1:0]  s_val;
	logic        [S2_W-1:0]            p_full;
	logic signed [spg_pkg::PROD_W:0]   rnd_x, rnd_s;
	logic signed [spg_pkg::GRAD_W-1:0] gx_sat, gs_sat;

	always_comb begin
		// Stage 3: magnitude of z; anything at or beyond 16.0 uses the table end.
		z_abs = z_s2[spg_pkg::Z_W-1] ? spg_pkg::Z_W'(-z_s2) : spg_pkg::Z_W'(z_s2);

		// Stage 4: table position |z|*depth/16 splits into index and fraction.
		pos = POS_W'(a_s3) * POS_W'(SIGMOID_TABLE_DEPTH);

		// Stage 6: interpolation step, rounded half up.
		ip = IP_W'(diff_s5) * IP_W'(fr_s5) + IP_HALF;

		// Stage 7: interpolated point, mirrored about one half for negative z.
		sp    = big_s6 ? last_ent : spg_pkg::ENT_W'(lo_s6 + spg_pkg::ENT_W'(interp_s6));
		s_val = neg_s6 ? (S_ONE - sp) : sp;

		// Stage 8: s*(1-s) in Q0.32.
		p_full = S2_W'(s_s7) * S2_W'(S_ONE - s_s7);

		// Stage 10: shift right by 32, rounding half away from zero. For a
		// negative value that equals adding one less than one half.
		rnd_x = (spg_pkg::PROD_W + 1)'(vx_s9) + (vx_s9[spg_pkg::PROD_W-1] ? BIAS_NEG : BIAS_POS);
		rnd_s = (spg_pkg::PROD_W + 1)'(vs_s9) + (vs_s9[spg_pkg::PROD_W-1] ? BIAS_NEG : BIAS_POS);

		// Stage 11: saturation.
		gx_sat = sat32(rx_s10);
		gs_sat = sat32(rs_s10);
	end

	spg_sig_rom #(
		.SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
	) u_rom (
		.clk      (clk),
		.en       (adv[5]),
		.idx      (idx_s4),
		.lo_s5    (lo_s5),
		.diff_s5  (diff_s5),
		.last_ent (last_ent)
	);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			d_s1 <= spg_pkg::D_W'(samp.sample_x) - spg_pkg::D_W'(xoff_q);
		end
		if (adv[2]) begin
			z_s2 <= spg_pkg::Z_W'(slope_q) * spg_pkg::Z_W'(d_s1);
			d_s2 <= d_s1;
		end
		if (adv[3]) begin
			a_s3   <= z_abs[spg_pkg::FR_W-1:0];
			big_s3 <= (z_abs[spg_pkg::Z_W-1:spg_pkg::FR_W] != '0);
			neg_s3 <= z_s2[spg_pkg::Z_W-1];
			d_s3   <= d_s2;
		end
		if (adv[4]) begin
			idx_s4 <= pos[spg_pkg::FR_W +: IDX_W];
			fr_s4  <= pos[spg_pkg::FR_W-1:0];
			big_s4 <= big_s3;
			neg_s4 <= neg_s3;
			d_s4   <= d_s3;
		end
		if (adv[5]) begin
			fr_s5  <= fr_s4;
			big_s5 <= big_s4;
			neg_s5 <= neg_s4;
			d_s5   <= d_s4;
		end
		if (adv[6]) begin
			interp_s6 <= ip[spg_pkg::FR_W +: spg_pkg::DIFF_W];
			lo_s6     <= lo_s5;
			big_s6    <= big_s5;
			neg_s6    <= neg_s5;
			d_s6      <= d_s5;
		end
		if (adv[7]) begin
			s_s7 <= s_val;
			d_s7 <= d_s6;
		end
		if (adv[8]) begin
			p_s8  <= p_full[spg_pkg::P_W-1:0];
			gd_s8 <= spg_pkg::Z_W'(gain_q) * spg_pkg::Z_W'(d_s7);
			// Exactly 1.0 does not fit in Q0.16 and clips to all ones.
			gg_s8 <= s_s7[spg_pkg::ENT_W-1] ? '1 : s_s7[spg_pkg::GG_W-1:0];
		end
		if (adv[9]) begin
			vx_s9 <= spg_pkg::PROD_W'(gsl_q) * spg_pkg::PROD_W'($signed({1'b0, p_s8}));
			vs_s9 <= spg_pkg::PROD_W'(gd_s8) * spg_pkg::PROD_W'($signed({1'b0, p_s8}));
			gg_s9 <= gg_s8;
		end
		if (adv[10]) begin
			rx_s10 <= rnd_x[spg_pkg::PROD_W -: spg_pkg::RND_W];
			rs_s10 <= rnd_s[spg_pkg::PROD_W -: spg_pkg::RND_W];
			gg_s10 <= gg_s9;
		end
		if (adv[11]) begin
			gx_s11  <= gx_sat;
			gs_s11  <= gs_sat;
			// The x offset gradient is the negated x gradient; the most
			// negative value has no positive twin and clips to the maximum.
			gxo_s11 <= (gx_sat == GRAD_MIN) ? GRAD_MAX : -gx_sat;
			gg_s11  <= gg_s10;
		end
	end

	assign grad.grad_gain     = gg_s11;
	assign grad.grad_x        = gx_s11;
	assign grad.grad_slope    = gs_s11;
	assign grad.grad_x_offset = gxo_s11;

endmodule
`default_nettype wire

>>> rtl/spg_sig_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sigmoid table
// Constant table of s(16*k/depth) in Q0.16, stored as base entry and slope
// to the next entry, read through a registered port.
// ----------------------------------------------------------------------------
module spg_sig_rom #(
	parameter int SIGMOID_TABLE_DEPTH = spg_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    en,
	input  wire logic [$clog2(SIGMOID_TABLE_DEPTH)-1:0]  idx,
	output logic      [spg_pkg::ENT_W-1:0]               lo_s5,
	output logic      [spg_pkg::DIFF_W-1:0]              diff_s5,
	output logic      [spg_pkg::ENT_W-1:0]               last_ent
);

	localparam logic [63:0] DEPTH64 = 64'(SIGMOID_TABLE_DEPTH);
	localparam logic [63:0] HALF64  = 64'(SIGMOID_TABLE_DEPTH / 2);

	localparam logic [63:0] U_END   = ((DEPTH64 << 30) + HALF64) / DEPTH64;
	localparam logic [63:0] DEN_END = spg_pkg::Q30_ONE + spg_pkg::exp_neg16(U_END);
	localparam logic [63:0] ENT_END = ((64'd1 << 46) + DEN_END / 2) / DEN_END;

	logic [spg_pkg::ENT_W-1:0]  lo_tbl   [SIGMOID_TABLE_DEPTH];
	logic [spg_pkg::DIFF_W-1:0] diff_tbl [SIGMOID_TABLE_DEPTH];

	for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_ent
		localparam logic [63:0] U_LO   = ((64'(k) << 30) + HALF64) / DEPTH64;
		localparam logic [63:0] U_HI   = ((64'(k + 1) << 30) + HALF64) / DEPTH64;
		localparam logic [63:0] DEN_LO = spg_pkg::Q30_ONE + spg_pkg::exp_neg16(U_LO);
		localparam logic [63:0] DEN_HI = spg_pkg::Q30_ONE + spg_pkg::exp_neg16(U_HI);
		localparam logic [63:0] ENT_LO = ((64'd1 << 46) + DEN_LO / 2) / DEN_LO;
		localparam logic [63:0] ENT_HI = ((64'd1 << 46) + DEN_HI / 2) / DEN_HI;
		// The curve rises everywhere, but a falling pair would clamp to a flat step.
		localparam logic [63:0] DIFF   = (ENT_HI >= ENT_LO) ? (ENT_HI - ENT_LO) : 64'd0;

		assign lo_tbl[k]   = ENT_LO[spg_pkg::ENT_W-1:0];
		assign diff_tbl[k] = DIFF[spg_pkg::DIFF_W-1:0];
	end

	assign last_ent = ENT_END[spg_pkg::ENT_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s5   <= lo_tbl[idx];
			diff_s5 <= diff_tbl[idx];
		end
	end

endmodule
`default_nettype wire

>>> rtl/spg_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sigmoid parameter gradient checker
// Port-level checks on transaction ordering and flow control, bound to the
// core.
// ----------------------------------------------------------------------------
module spg_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_valid,
	input wire logic                              s_ready,
	input wire logic                              g_valid,
	input wire logic                              g_ready,
	input wire logic        [spg_pkg::GG_W-1:0]   g_grad_gain,
	input wire logic signed [spg_pkg::GRAD_W-1:0] g_grad_x,
	input wire logic signed [spg_pkg::GRAD_W-1:0] g_grad_slope,
	input wire logic signed [spg_pkg::GRAD_W-1:0] g_grad_x_offset
);

	localparam int CNT_W = $clog2(spg_pkg::PIPE_STAGES + 2);

	// Samples taken whose results have not yet been delivered.
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(s_valid && s_ready) - CNT_W'(g_valid && g_ready);
		end
	end

	// A result waiting on the sink holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		g_valid && !g_ready |=> g_valid && $stable(g_grad_gain) && $stable(g_grad_x)
			&& $stable(g_grad_slope) && $stable(g_grad_x_offset))
		else $error("result changed while stalled");

	// No result appears without a sample behind it.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		g_valid |-> cnt_q != '0)
		else $error("result without a pending sample");

	// The pipeline never holds more samples than it has stages.
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(spg_pkg::PIPE_STAGES))
		else $error("more samples in flight than pipeline stages");

	// With the output register empty, every stage can move, so s_ready is high.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!g_valid |-> s_ready)
		else $error("input stalled while output is empty");

endmodule

bind sigmoid_parameter_gradient_core spg_chk u_spg_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.s_valid         (samp.valid),
	.s_ready         (samp.ready),
	.g_valid         (grad.valid),
	.g_ready         (grad.ready),
	.g_grad_gain     (grad.grad_gain),
	.g_grad_x        (grad.grad_x),
	.g_grad_slope    (grad.grad_slope),
	.g_grad_x_offset (grad.grad_x_offset)
);
`default_nettype wire

>>> sim/tb_sigmoid_parameter_gradient_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigmoid parameter gradient core testbench
// Drives samples and register writes into the core under random idling and
// back-pressure, and checks each gradient result against a bit-exact
// fixed-point predictor that builds its own interpolated sigmoid table.
// ----------------------------------------------------------------------------
module tb_sigmoid_parameter_gradient_core;

	localparam int TABLE_DEPTH = spg_pkg::TABLE_DEPTH_DEF;

	// Index 3 is not a register; writes to it must leave the settings alone.
	localparam logic [spg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam int MISMATCH_SHOW = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int RX_HOLD       = 200;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_ITEMS   = 115;

	localparam longint GRAD_MAX = (longint'(1) << 31) - 1;
	localparam longint GRAD_MIN = -(longint'(1) << 31);

	// One expected result transaction.
	typedef struct {
		logic        [spg_pkg::GG_W-1:0]   gain_grad;
		logic signed [spg_pkg::GRAD_W-1:0] x_grad;
		logic signed [spg_pkg::GRAD_W-1:0] slope_grad;
		logic signed [spg_pkg::GRAD_W-1:0] xoff_grad;
	} grad_set_t;

	// ------------------------------------------------------------------------
	// Gradient scoreboard. It keeps its own copy of the three settings and of
	// the sigmoid table, predicts the four gradients of every accepted sample
	// and compares each result transaction with the oldest prediction.
	// ------------------------------------------------------------------------
	class gradient_scoreboard;
		logic signed [spg_pkg::CFG_W-1:0] gain;
		logic signed [spg_pkg::CFG_W-1:0] slope;
		logic signed [spg_pkg::CFG_W-1:0] x_off;
		longint unsigned                  sig_table[];
		grad_set_t                        expected_q[$];
		int                               n_samples;
		int                               n_checked;
		int                               n_errors;

		function new();
			longint unsigned u;
			longint unsigned den;
			gain      = spg_pkg::GAIN_RST;
			slope     = spg_pkg::SLOPE_RST;
			x_off     = spg_pkg::X_OFFSET_RST;
			n_samples = 0;
			n_checked = 0;
			n_errors  = 0;
			// Entry k holds s(16*k/DEPTH) in Q0.16.
			sig_table = new[TABLE_DEPTH + 1];
			for (int k = 0; k <= TABLE_DEPTH; k++) begin
				u   = ((longint'(k) << 30) + TABLE_DEPTH / 2) / TABLE_DEPTH;
				den = spg_pkg::Q30_ONE + exp_neg16_q30(u);
				sig_table[k] = ((64'd1 << 46) + den / 2) / den;
			end
		endfunction

		// exp(-16u) in Q0.30: a degree-14 Horner series at u, squared four times.
		function longint unsigned exp_neg16_q30(longint unsigned u);
			longint unsigned r;
			r = spg_pkg::Q30_ONE;
			for (longint unsigned k = 14; k >= 1; k--) begin
				r = spg_pkg::Q30_ONE - ((u * r) >> 30) / k;
			end
			repeat (4) begin
				r = (r * r + (64'd1 << 29)) >> 30;
			end
			return r;
		endfunction

		// Sigmoid in Q0.16 of z in Q.16, interpolated between table points.
		function longint unsigned logistic_q16(longint z);
			longint unsigned a;
			longint unsigned pos;
			longint unsigned idx;
			longint unsigned fr;
			longint unsigned diff;
			longint unsigned sp;
			a = (z < 0) ? -z : z;
			if (a >= (64'd16 << 16)) begin
				sp = sig_table[TABLE_DEPTH];
			end else begin
				pos  = a * TABLE_DEPTH;
				idx  = pos >> 20;
				fr   = pos & 64'hFFFFF;
				diff = (sig_table[idx + 1] >= sig_table[idx]) ?
					sig_table[idx + 1] - sig_table[idx] : 0;
				sp   = sig_table[idx] + ((diff * fr + (64'd1 << 19)) >> 20);
			end
			return (z < 0) ? 65536 - sp : sp;
		endfunction

		// Drop 32 fraction bits, rounding ties away from zero, then saturate.
		function longint round_shift32(longint v);
			longint unsigned m;
			m = (v < 0) ? -v : v;
			m = (m + (64'd1 << 31)) >> 32;
			if (v >= 0) begin
				return (m > GRAD_MAX) ? GRAD_MAX : longint'(m);
			end
			if (m > 64'h80000000) begin
				m = 64'h80000000;
			end
			return -longint'(m);
		endfunction

		function void apply_write(logic [spg_pkg::CFG_IDX_W-1:0] idx,
			logic [spg_pkg::CFG_W-1:0] value);
			case (idx)
				spg_pkg::CFG_GAIN: begin
					gain = value;
				end
				spg_pkg::CFG_SLOPE: begin
					slope = value;
				end
				spg_pkg::CFG_X_OFFSET: begin
					x_off = value;
				end
				default: begin
				end
			endcase
		endfunction

		function void note_sample(logic signed [spg_pkg::X_W-1:0] x);
			longint    d;
			longint    z;
			longint    s;
			longint    p;
			longint    gx;
			longint    gs;
			grad_set_t e;
			d  = longint'(x) - longint'(x_off);
			z  = longint'(slope) * d;
			s  = longint'(logistic_q16(z));
			p  = s * (65536 - s);
			gx = round_shift32(longint'(gain) * longint'(slope) * p);
			gs = round_shift32(longint'(gain) * d * p);
			e.gain_grad  = (s > 65535) ? 16'hFFFF : s[spg_pkg::GG_W-1:0];
			e.x_grad     = gx[spg_pkg::GRAD_W-1:0];
			e.slope_grad = gs[spg_pkg::GRAD_W-1:0];
			e.xoff_grad  = (gx <= GRAD_MIN) ? GRAD_MAX[spg_pkg::GRAD_W-1:0] :
				-gx[spg_pkg::GRAD_W-1:0];
			expected_q.push_back(e);
			n_samples++;
		endfunction

		function void check_result(logic [spg_pkg::GG_W-1:0] gg,
			logic signed [spg_pkg::GRAD_W-1:0] gx,
			logic signed [spg_pkg::GRAD_W-1:0] gs,
			logic signed [spg_pkg::GRAD_W-1:0] gxo);
			grad_set_t e;
			if (expected_q.size() == 0) begin
				n_errors++;
				if (n_errors <= MISMATCH_SHOW) begin
					$display("ERROR %0t: result with no sample outstanding: %0d %0d %0d %0d",
						$realtime, gg, gx, gs, gxo);
				end
				return;
			end
			e = expected_q.pop_front();
			n_checked++;
			if (gg !== e.gain_grad || gx !== e.x_grad || gs !== e.slope_grad ||
				gxo !== e.xoff_grad) begin
				n_errors++;
				if (n_errors <= MISMATCH_SHOW) begin
					$display("ERROR %0t: result %0d (gain %0d slope %0d x_offset %0d)",
						$realtime, n_checked, gain, slope, x_off);
					$display("  expected gain %0d x %0d slope %0d x_offset %0d",
						e.gain_grad, e.x_grad, e.slope_grad, e.xoff_grad);
					$display("  actual   gain %0d x %0d slope %0d x_offset %0d",
						gg, gx, gs, gxo);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the core.
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always #1 clk = ~clk;

	spg_cfg_if    cfg_ch ();
	spg_sample_if samp_ch ();
	spg_grad_if   grad_ch ();

	sigmoid_parameter_gradient_core #(
		.SIGMOID_TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.samp   (samp_ch),
		.grad   (grad_ch)
	);

	gradient_scoreboard sb;

	// no_idle and rx_hold_req are shared between the stimulus and the output
	// side. When no_idle is set, neither side inserts gaps; rx_hold_req asks
	// the output side for one long stretch of back-pressure.
	bit                               no_idle;
	int                               rx_hold_req;
	int                               n_settings;
	logic signed [spg_pkg::CFG_W-1:0] cur_slope;
	logic signed [spg_pkg::CFG_W-1:0] cur_off;

	// All three channels are observed at the rising edge, before any register
	// in the core updates, so every transaction is seen with the values that
	// were actually exchanged. A register write lands in the scoreboard on
	// the same edge at which the core takes it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				sb.apply_write(cfg_ch.index, cfg_ch.data);
			end
			if (samp_ch.valid && samp_ch.ready) begin
				sb.note_sample(samp_ch.sample_x);
			end
			if (grad_ch.valid && grad_ch.ready) begin
				sb.check_result(grad_ch.grad_gain, grad_ch.grad_x, grad_ch.grad_slope,
					grad_ch.grad_x_offset);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output side. Before each result transaction it holds ready low for a random
	// gap, none when no_idle is set; on request it holds ready low for a long
	// stretch, counted here, so that the pipeline fills and stalls its input.
	// ------------------------------------------------------------------------
	initial begin : output_side
		int gap;
		int hold;
		grad_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_req > 0) begin
				hold        = rx_hold_req;
				rx_hold_req = 0;
				repeat (hold) begin
					@(negedge clk);
					grad_ch.ready <= 1'b0;
				end
			end
			gap = no_idle ? 0 : $urandom_range(0, 5);
			repeat (gap) begin
				@(negedge clk);
				grad_ch.ready <= 1'b0;
			end
			@(negedge clk);
			grad_ch.ready <= 1'b1;
			do @(posedge clk); while (!(grad_ch.valid && grad_ch.ready));
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks. Everything changes on the falling edge; send_sample
	// returns on the rising edge at which its sample was taken.
	// ------------------------------------------------------------------------

	// Offers one sample after a random gap. During the gap the data lines
	// carry noise, which the core must ignore while valid is low.
	task automatic send_sample(input logic [spg_pkg::X_W-1:0] x);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			samp_ch.valid    <= 1'b0;
			samp_ch.sample_x <= spg_pkg::X_W'($urandom);
		end
		@(negedge clk);
		samp_ch.valid    <= 1'b1;
		samp_ch.sample_x <= x;
		do @(posedge clk); while (!(samp_ch.valid && samp_ch.ready));
	endtask

	// Ends a burst of samples and waits until every prediction is matched.
	// Every sample yields a result, so once the store of predictions is
	// empty the pipeline is empty too and the settings may change.
	task automatic settle();
		@(negedge clk);
		samp_ch.valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_register(input logic [spg_pkg::CFG_IDX_W-1:0] idx,
		input logic [spg_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [spg_pkg::CFG_W-1:0] g,
		input logic [spg_pkg::CFG_W-1:0] s, input logic [spg_pkg::CFG_W-1:0] o);
		write_register(spg_pkg::CFG_GAIN, g);
		write_register(spg_pkg::CFG_SLOPE, s);
		write_register(spg_pkg::CFG_X_OFFSET, o);
		cur_slope = s;
		cur_off   = o;
		n_settings++;
	endtask

	// Register values lean toward small magnitudes, where the sigmoid is
	// actually curved, but the extremes and full-range values come up often.
	function automatic logic [spg_pkg::CFG_W-1:0] pick_setting();
		case ($urandom_range(0, 5))
			0: begin
				return 16'h7FFF;
			end
			1: begin
				return 16'h8000;
			end
			2: begin
				return spg_pkg::CFG_W'($urandom);
			end
			default: begin
				return spg_pkg::CFG_W'($urandom_range(0, 1023) - 512);
			end
		endcase
	endfunction

	// Three samples in four are aimed where |slope*(x - x_offset)| < 16, so that
	// the table interpolation is exercised rather than the flat tails; the
	// rest cover the whole 16-bit range.
	function automatic logic [spg_pkg::X_W-1:0] pick_sample(
		input logic signed [spg_pkg::CFG_W-1:0] s,
		input logic signed [spg_pkg::CFG_W-1:0] o);
		int mag;
		int lim;
		if ($urandom_range(0, 3) == 0) begin
			return spg_pkg::X_W'($urandom);
		end
		mag = (s < 0) ? -int'(s) : int'(s);
		lim = (mag == 0) ? 32767 : (1 << 20) / mag + 2;
		if (lim > 32767) begin
			lim = 32767;
		end
		return spg_pkg::X_W'(int'(o) + int'($urandom_range(0, 2 * lim)) - lim);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus: a directed part at the corners, then random phases, each
	// with fresh settings written while the core is idle.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		sb               = new();
		arst_n           = 1'b0;
		samp_ch.valid    = 1'b0;
		samp_ch.sample_x = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = spg_pkg::CFG_GAIN;
		cfg_ch.data      = '0;
		no_idle          = 1'b0;
		rx_hold_req      = 0;
		n_settings       = 1;
		cur_slope        = spg_pkg::SLOPE_RST;
		cur_off          = spg_pkg::X_OFFSET_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings (gain 1.0, slope 1.0, no offset): the centre, the
		// sample extremes, the smallest steps either side and 1.0 itself.
		send_sample(16'h0000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0001);
		send_sample(16'hFFFF);
		send_sample(16'h0100);
		settle();

		// A write to the unused index must not disturb the settings.
		write_register(CFG_UNUSED, 16'hA5A5);
		send_sample(16'h0080);
		send_sample(16'hFF80);
		settle();

		// Largest gain and slope, most negative offset: two samples sit on the top
		// entry, where the gain gradient saturates and the other gradients vanish.
		apply_settings(16'h7FFF, 16'h7FFF, 16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		settle();

		// Most negative gain and slope, largest offset: largest positive products.
		apply_settings(16'h8000, 16'h8000, 16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h7FFE);
		settle();

		// Smallest positive slope with the most negative gain: wide curved
		// region and the biggest slope gradients.
		apply_settings(16'h8000, 16'h0001, 16'h0000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0123);
		settle();

		// Zero slope: s stays at one half for every sample.
		apply_settings(16'h7FFF, 16'h0000, 16'h1234);
		send_sample(16'h0000);
		send_sample(16'h8000);
		settle();

		// Unit slope near the end of the table: a point at 15.0 inside the
		// interpolated range, the exact boundary at 16.0, and its mirror image.
		apply_settings(16'h0100, 16'h0100, 16'h0000);
		send_sample(16'h0F00);
		send_sample(16'h1000);
		send_sample(16'hF000);
		settle();

		// Random phases. Two run with no idling on either side, one carries
		// the long output stall and one pauses the input until it drains.
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			apply_settings(pick_setting(), pick_setting(), pick_setting());
			if (phase % 4 == 3) begin
				write_register(CFG_UNUSED, spg_pkg::CFG_W'($urandom));
			end
			no_idle = (phase == 2 || phase == 7);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 4 && i == 20) begin
					rx_hold_req = RX_HOLD;
				end
				if (phase == 5 && i == PHASE_ITEMS / 2) begin
					settle();
				end
				send_sample(pick_sample(cur_slope, cur_off));
			end
			settle();
		end
		no_idle = 1'b0;

		// Let any stray result come out before the verdict.
		repeat (4 * spg_pkg::PIPE_STAGES) @(posedge clk);

		$display("Covered %0d samples under %0d register settings, with a %0d-cycle output stall.",
			sb.n_samples, n_settings, RX_HOLD);
		$display("Compared %0d results: %0d errors, %0d predictions left unmatched.",
			sb.n_checked, sb.n_errors, sb.pending());
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("sigmoid_parameter_gradient_core regression: pass");
		end else begin
			$display("sigmoid_parameter_gradient_core regression: fail");
		end
		$finish;
	end

	// A healthy run takes well under a tenth of this time.
	initial begin : watchdog
		#400000;
		$display("Timed out with %0d predictions outstanding.", sb.pending());
		$display("sigmoid_parameter_gradient_core regression: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/spg_pkg.sv
rtl/spg_ifs.sv
rtl/spg_sig_rom.sv
rtl/sigmoid_parameter_gradient_core.sv
rtl/spg_chk.sv
sim/tb_sigmoid_parameter_gradient_core.sv
